### rtl/ovle_pkg.sv
// ---------------------------------------------------------------------------
// Ordered value list engine - shared definitions
// Depth, widths, operation and status codes used by the list engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ovle_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 4;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // show never emits more than sixteen results
  localparam int SHOW_N  = (DEPTH < 16) ? DEPTH : 16;

  localparam int IN_TDATA_W  = ((2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - POS_W;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_SEARCH = 3'd1,
    OP_MODIFY = 3'd2,
    OP_DELETE = 3'd3,
    OP_SHOW   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

endpackage

`default_nettype wire

### rtl/ordered_value_list_engine_top.sv
// ---------------------------------------------------------------------------
// Ordered value list engine
// Ordered list of signed values in a single-port-read memory: append,
// search, modify, delete with gap closing, and show of every entry.
// ---------------------------------------------------------------------------
//
//  channel   direction  tuser              tdata                    tlast
//  s_axis    in         operation [2:0]    key_value, replacement   -
//  m_axis    out        status [1:0]       entry_value, position    last result
//
//  Append and the empty, full and unknown cases go straight to S_RESP,
//  which loads the result. Search and modify issue one memory read a cycle,
//  each entry compared in the cycle after its read. Delete then closes the
//  gap, each read of the memory behind the match feeding a write one
//  position lower.
//  Show issues one read a cycle and emits up to sixteen results back to back.
//  Reset clears the entry count; memory contents are never read before they
//  are written. A stalled result holds the engine; a request is taken once
//  the previous one has placed all its results in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_value_list_engine_top
  import ovle_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // request channel
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire logic [2:0]              s_axis_tuser_i,   // [2:0] operation
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata_i,   // [31:0] key_value, [63:32] replacement
  // result channel
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  output logic [1:0]                   m_axis_tuser_o,   // [1:0] status
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata_o,   // [31:0] entry_value, [35:32] position
  output logic                         m_axis_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SHOW,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [DATA_W-1:0]   key_q, key_d;
  logic [DATA_W-1:0]   repl_q, repl_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic                vld_q, vld_d;
  status_e             res_status_q, res_status_d;
  logic [POS_W-1:0]    res_pos_q, res_pos_d;

  logic                out_vld_q, out_vld_d;
  status_e             out_status_q, out_status_d;
  logic [DATA_W-1:0]   out_value_q, out_value_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic                out_last_q, out_last_d;

  logic [DATA_W-1:0]   mem_q [DEPTH];
  logic [DATA_W-1:0]   rdata_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic                req_acc;
  logic                can_load;
  logic                hit;
  logic                issue;
  logic [CNT_W-1:0]    show_n;
  op_e                 req_op;

  assign req_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign can_load = !out_vld_q || m_axis_tready_i;
  assign hit      = vld_q && (rdata_q == key_q);
  assign show_n   = (cnt_q < CNT_W'(SHOW_N)) ? cnt_q : CNT_W'(SHOW_N);
  assign req_op   = op_e'(s_axis_tuser_i);

  // List store: one write and one registered read per cycle. Writes always
  // land below the pending read address, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    repl_d       = repl_q;
    cnt_d        = cnt_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    vld_d        = vld_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    issue        = 1'b0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          op_d      = req_op;
          key_d     = s_axis_tdata_i[DATA_W-1:0];
          repl_d    = s_axis_tdata_i[2*DATA_W-1:DATA_W];
          rd_ptr_d  = '0;
          vld_d     = 1'b0;
          res_pos_d = '0;
          case (req_op)
            OP_APPEND: begin
              state_d = S_RESP;
              if (cnt_q >= CNT_W'(DEPTH)) begin
                res_status_d = STS_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = cnt_q[ADDR_W-1:0];
                mem_wdata    = s_axis_tdata_i[DATA_W-1:0];
                res_status_d = STS_OK;
                res_pos_d    = POS_W'(cnt_q);
                cnt_d        = cnt_q + CNT_W'(1);
              end
            end
            OP_SEARCH, OP_MODIFY, OP_DELETE: begin
              if (cnt_q == '0) begin
                res_status_d = STS_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_SHOW: begin
              if (cnt_q == '0) begin
                res_status_d = STS_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_SHOW;
              end
            end
            default: begin
              res_status_d = STS_NOT_FOUND;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one entry a cycle, compare the one read last cycle
        issue = (rd_ptr_q < cnt_q) && !hit;
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q[ADDR_W-1:0];
          rd_ptr_d  = rd_ptr_q + CNT_W'(1);
          wr_ptr_d  = rd_ptr_q;
        end
        vld_d = issue;
        if (hit) begin
          res_status_d = STS_OK;
          res_pos_d    = POS_W'(wr_ptr_q);
          case (op_q)
            OP_MODIFY: begin
              mem_we    = 1'b1;
              mem_waddr = wr_ptr_q[ADDR_W-1:0];
              mem_wdata = repl_q;
              state_d   = S_RESP;
            end
            OP_DELETE: begin
              rd_ptr_d = wr_ptr_q + CNT_W'(1);
              wr_ptr_d = wr_ptr_q;
              vld_d    = 1'b0;
              state_d  = S_SHIFT;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end else if (vld_q && (wr_ptr_q == cnt_q - CNT_W'(1))) begin
          res_status_d = STS_NOT_FOUND;
          res_pos_d    = '0;
          state_d      = S_RESP;
        end
      end

      S_SHIFT: begin
        // close the gap: entry i+1 moves down to i
        issue = rd_ptr_q < cnt_q;
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q[ADDR_W-1:0];
          rd_ptr_d  = rd_ptr_q + CNT_W'(1);
        end
        vld_d = issue;
        if (vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_ptr_q[ADDR_W-1:0];
          mem_wdata = rdata_q;
          wr_ptr_d  = wr_ptr_q + CNT_W'(1);
        end
        if (!issue && !vld_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      S_SHOW: begin
        // vld_q marks read data waiting for the output register
        if (vld_q && can_load) begin
          out_vld_d    = 1'b1;
          out_status_d = STS_OK;
          out_value_d  = rdata_q;
          out_pos_d    = POS_W'(wr_ptr_q);
          out_last_d   = (wr_ptr_q + CNT_W'(1)) == show_n;
          vld_d        = 1'b0;
          if ((wr_ptr_q + CNT_W'(1)) == show_n) begin
            state_d = S_IDLE;
          end
        end
        issue = (rd_ptr_q < show_n) && (!vld_q || can_load);
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = rd_ptr_q[ADDR_W-1:0];
          rd_ptr_d  = rd_ptr_q + CNT_W'(1);
          wr_ptr_d  = rd_ptr_q;
          vld_d     = 1'b1;
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = '0;
          out_pos_d    = res_pos_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_APPEND;
      key_q        <= '0;
      repl_q       <= '0;
      cnt_q        <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      vld_q        <= 1'b0;
      res_status_q <= STS_OK;
      res_pos_q    <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= STS_OK;
      out_value_q  <= '0;
      out_pos_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      repl_q       <= repl_d;
      cnt_q        <= cnt_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      vld_q        <= vld_d;
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      out_vld_q    <= out_vld_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_pos_q    <= out_pos_d;
      out_last_q   <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_pos_q, out_value_q};
  assign m_axis_tlast_o  = out_last_q;

  // entry count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // reads only touch entries that hold list data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (CNT_W'(mem_raddr) < cnt_q))
    else $error("read beyond list tail");

  // an append on a list with room grows it by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_op == OP_APPEND) && (cnt_q < CNT_W'(DEPTH)))
      |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not grow the list");

endmodule

`default_nettype wire
